### hdl/assert_macros.svh
// Assertion macros used by the logger top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### hdl/ppsl_pkg.sv
// Shared constants and types for the power period statistics logger.
package ppsl_pkg;
	localparam logic [2:0] CMD_READING = 3'd0;
	localparam logic [2:0] CMD_RESTART = 3'd1;
	localparam logic [2:0] CMD_MAX_WIN = 3'd2;
	localparam logic [2:0] CMD_MIN_WIN = 3'd3;
	localparam logic [2:0] CMD_MAX_LEN = 3'd4;
	localparam logic [2:0] CMD_MIN_LEN = 3'd5;
	localparam logic [15:0] VALUE_CEIL = 16'hFFFF;
	localparam logic [31:0] PERIOD_LENGTH_RST = 32'd1000;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] power_value;
		logic [31:0] fetch_time;
		logic [31:0] window_start;
		logic [31:0] window_end;
		logic [31:0] window_length;
	} in_word_t;

	typedef struct packed {
		logic        accepted;
		logic        period_closed;
		logic [31:0] closed_start;
		logic [15:0] closed_min;
		logic [15:0] closed_max;
		logic [15:0] closed_average;
		logic [15:0] query_value;
	} out_word_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
		logic [31:0] remainder;
	} div_rsp_t;
endpackage

### hdl/ppsl_if.sv
// Valid/ready channel carrying one word.
interface ppsl_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/power_period_stats_logger.sv
// Top level of the power period statistics logger.
// Path, accept to result valid: stale, restart, unused and empty-history words go from decode
// straight to output; an in-period reading passes multiply and accumulate; a period-closing
// reading first waits on the realignment and average divisions where needed. Queries read and
// scan the history entries. One word in flight: a new word is accepted only after the result is taken.
// Reset is asynchronous, active low; period start loads initial_period_start.
`include "assert_macros.svh"
module power_period_stats_logger #(
	parameter int HISTORY_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ppsl_if.sink        in_ch,
	ppsl_if.source      out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
	localparam int CW = $clog2(HISTORY_SLOTS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_REAL  = 4'd2;
	localparam logic [3:0] S_AVG   = 4'd3;
	localparam logic [3:0] S_PUSH  = 4'd4;
	localparam logic [3:0] S_ACC   = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_QRD   = 4'd7;
	localparam logic [3:0] S_QCHK  = 4'd8;
	localparam logic [3:0] S_QRD2  = 4'd9;
	localparam logic [3:0] S_QSCAN = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	localparam logic [3:0] ADDR_PLEN  = 4'd0;
	localparam logic [3:0] ADDR_DEPTH = 4'd4;
	localparam logic [3:0] ADDR_INIT  = 4'd8;

	logic [31:0] plen_q;
	logic [6:0]  depth_q;
	logic [31:0] init_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= ppsl_pkg::PERIOD_LENGTH_RST;
			depth_q <= 7'd64;
			init_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr)
				ADDR_PLEN:  plen_q <= pwdata;
				ADDR_DEPTH: depth_q <= pwdata[6:0];
				ADDR_INIT:  init_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_PLEN:  prdata = plen_q;
			ADDR_DEPTH: prdata = {25'd0, depth_q};
			ADDR_INIT:  prdata = init_q;
			default:    prdata = '0;
		endcase
	end

	// Effective depth, clamped to 1..HISTORY_SLOTS.
	logic [CW-1:0] depth_eff;
	always_comb begin
		if (depth_q == 7'd0)
			depth_eff = CW'(1);
		else if ({25'd0, depth_q} > 32'(HISTORY_SLOTS))
			depth_eff = CW'(HISTORY_SLOTS);
		else
			depth_eff = CW'(depth_q);
	end

	logic [3:0]  state_q;
	ppsl_pkg::in_word_t  in_q;
	ppsl_pkg::out_word_t res_q;
	logic        init_pend_q;

	logic [31:0] last_q;
	logic [31:0] pbeg_q;
	logic [31:0] prev_q;
	logic        have_q;
	logic [15:0] rmin_q;
	logic [15:0] rmax_q;
	logic [63:0] wsum_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic [31:0] hs_mem [HISTORY_SLOTS];
	logic [15:0] hmin_mem [HISTORY_SLOTS];
	logic [15:0] hmax_mem [HISTORY_SLOTS];
	logic [AW-1:0] rd_addr;
	logic [31:0] rd_start_s1;
	logic [15:0] rd_min_s1;
	logic [15:0] rd_max_s1;
	logic        wr_en;

	logic [CW-1:0] k_q;
	logic        started_q;
	logic [15:0] lim_q;
	logic        want_max_q;
	logic [31:0] ws_q;
	logic [31:0] we_q;
	logic        div_phase_q;
	logic [63:0] prod_q;

	ppsl_pkg::div_req_t div_req;
	ppsl_pkg::div_rsp_t div_rsp;

	ppsl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Slot k back from head (1 = newest).
	function automatic logic [AW-1:0] back_slot(input logic [AW-1:0] head,
			input logic [CW-1:0] back);
		logic [AW:0] t;
		begin
			t = {1'b0, head} + (AW+1)'(HISTORY_SLOTS) - (AW+1)'(back);
			if (t >= (AW+1)'(HISTORY_SLOTS))
				t = t - (AW+1)'(HISTORY_SLOTS);
			back_slot = t[AW-1:0];
		end
	endfunction

	assign rd_addr = back_slot(head_q, k_q);
	assign wr_en = (state_q == S_PUSH) && have_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hs_mem[head_q] <= pbeg_q;
			hmin_mem[head_q] <= rmin_q;
			hmax_mem[head_q] <= rmax_q;
		end
		rd_start_s1 <= hs_mem[rd_addr];
		rd_min_s1 <= hmin_mem[rd_addr];
		rd_max_s1 <= hmax_mem[rd_addr];
	end

	logic [32:0] pend_sum;
	logic [31:0] dt;
	assign pend_sum = {1'b0, pbeg_q} + {1'b0, plen_q};
	assign dt = in_q.fetch_time - prev_q;

	always_comb begin
		div_req = '0;
		if (state_q == S_DEC && in_q.cmd == ppsl_pkg::CMD_READING
				&& in_q.fetch_time > last_q && {1'b0, in_q.fetch_time} > pend_sum
				&& plen_q != 32'd0) begin
			div_req.start = 1'b1;
			div_req.dividend = {32'd0, in_q.fetch_time};
			div_req.divisor = plen_q;
		end else if (state_q == S_REAL && (!div_phase_q || div_rsp.done) && have_q
				&& (prev_q - pbeg_q) != 32'd0) begin
			div_req.start = 1'b1;
			div_req.dividend = wsum_q;
			div_req.divisor = prev_q - pbeg_q;
		end
	end

	assign in_ch.ready = (state_q == S_IDLE) && !init_pend_q;
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data = res_q;

	logic [63:0] sum_next;
	logic        sum_ovf;
	assign {sum_ovf, sum_next} = {1'b0, wsum_q} + {1'b0, prod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_pend_q <= 1'b1;
			last_q <= '0;
			have_q <= 1'b0;
			rmin_q <= '0;
			rmax_q <= '0;
			wsum_q <= '0;
			head_q <= '0;
			count_q <= '0;
			pbeg_q <= '0;
			prev_q <= '0;
			div_phase_q <= 1'b0;
		end else begin
			if (init_pend_q) begin
				init_pend_q <= 1'b0;
				pbeg_q <= init_q;
				prev_q <= init_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						in_q <= in_ch.data;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_q <= '0;
					started_q <= 1'b0;
					unique case (in_q.cmd)
						ppsl_pkg::CMD_READING: begin
							if (in_q.fetch_time <= last_q)
								state_q <= S_OUT;
							else if ({1'b0, in_q.fetch_time} > pend_sum) begin
								div_phase_q <= (plen_q != 32'd0);
								state_q <= S_REAL;
							end else
								state_q <= S_MUL;
						end
						ppsl_pkg::CMD_RESTART: begin
							have_q <= 1'b0;
							rmin_q <= '0;
							rmax_q <= '0;
							wsum_q <= '0;
							head_q <= '0;
							count_q <= '0;
							pbeg_q <= in_q.fetch_time;
							prev_q <= in_q.fetch_time;
							state_q <= S_OUT;
						end
						ppsl_pkg::CMD_MAX_WIN, ppsl_pkg::CMD_MIN_WIN,
						ppsl_pkg::CMD_MAX_LEN, ppsl_pkg::CMD_MIN_LEN: begin
							want_max_q <= (in_q.cmd == ppsl_pkg::CMD_MAX_WIN)
								|| (in_q.cmd == ppsl_pkg::CMD_MAX_LEN);
							if (in_q.cmd == ppsl_pkg::CMD_MAX_WIN
									|| in_q.cmd == ppsl_pkg::CMD_MIN_WIN) begin
								ws_q <= in_q.window_start;
								we_q <= in_q.window_end;
							end else begin
								ws_q <= pbeg_q - in_q.window_length;
								we_q <= pbeg_q;
							end
							lim_q <= ((in_q.cmd == ppsl_pkg::CMD_MAX_WIN)
								|| (in_q.cmd == ppsl_pkg::CMD_MAX_LEN))
								? 16'd0 : ppsl_pkg::VALUE_CEIL;
							if (count_q == '0)
								state_q <= S_OUT;
							else begin
								k_q <= count_q;
								state_q <= S_QRD;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_REAL: begin
					// Wait on realignment division (if any), then start the average.
					if (!div_phase_q || div_rsp.done) begin
						if (have_q) begin
							res_q.period_closed <= 1'b1;
							res_q.closed_start <= pbeg_q;
							res_q.closed_min <= rmin_q;
							res_q.closed_max <= rmax_q;
							if ((prev_q - pbeg_q) == 32'd0) begin
								res_q.closed_average <= '0;
								state_q <= S_PUSH;
							end else
								state_q <= S_AVG;
						end else
							state_q <= S_PUSH;
						// Stash the offset of the new period start (fetch time mod length) in ws_q until the push.
						ws_q <= div_phase_q ? div_rsp.remainder : 32'd0;
					end
				end
				S_AVG: begin
					if (div_rsp.done) begin
						res_q.closed_average <= (div_rsp.quotient[63:16] != '0)
							? ppsl_pkg::VALUE_CEIL : div_rsp.quotient[15:0];
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (have_q) begin
						head_q <= (head_q == AW'(HISTORY_SLOTS - 1)) ? '0 : head_q + AW'(1);
						if (count_q < depth_eff)
							count_q <= count_q + CW'(1);
					end
					have_q <= 1'b0;
					rmin_q <= '0;
					rmax_q <= '0;
					wsum_q <= '0;
					pbeg_q <= in_q.fetch_time - ws_q;
					prev_q <= in_q.fetch_time - ws_q;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= {48'd0, in_q.power_value} * {32'd0, dt};
					state_q <= S_ACC;
				end
				S_ACC: begin
					wsum_q <= sum_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : sum_next;
					if (!have_q) begin
						rmin_q <= in_q.power_value;
						rmax_q <= in_q.power_value;
					end else begin
						if (in_q.power_value > rmax_q) rmax_q <= in_q.power_value;
						if (in_q.power_value < rmin_q) rmin_q <= in_q.power_value;
					end
					have_q <= 1'b1;
					prev_q <= in_q.fetch_time;
					last_q <= in_q.fetch_time;
					res_q.accepted <= 1'b1;
					state_q <= S_OUT;
				end
				S_QRD: begin
					// Oldest entry being read.
					state_q <= S_QCHK;
				end
				S_QCHK: begin
					if (rd_start_s1 > we_q)
						state_q <= S_OUT;
					else begin
						k_q <= CW'(1);
						state_q <= S_QRD2;
					end
				end
				S_QRD2: begin
					state_q <= S_QSCAN;
				end
				S_QSCAN: begin
					if (k_q == CW'(1) && rd_start_s1 < ws_q)
						state_q <= S_OUT;
					else begin
						if ((started_q || rd_start_s1 < we_q) && rd_start_s1 < ws_q) begin
							res_q.query_value <= lim_q;
							state_q <= S_OUT;
						end else begin
							logic [15:0] nl;
							nl = lim_q;
							if (started_q || rd_start_s1 < we_q) begin
								started_q <= 1'b1;
								if (want_max_q && rd_max_s1 > lim_q) nl = rd_max_s1;
								if (!want_max_q && rd_min_s1 < lim_q) nl = rd_min_s1;
							end
							lim_q <= nl;
							if (k_q == count_q) begin
								res_q.query_value <= nl;
								state_q <= S_OUT;
							end else begin
								k_q <= k_q + CW'(1);
								state_q <= S_QRD2;
							end
						end
					end
				end
				S_OUT: begin
					if (out_ch.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ch.ready, state_q == S_IDLE, "ready outside idle")
	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(HISTORY_SLOTS), "count overflow")
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready,
		"accepted while busy")
	`ASSERT_IMPL(a_closed_acc, clk, arst_n, out_ch.valid && out_ch.data.period_closed,
		out_ch.data.accepted, "closed without accepting")
endmodule

### hdl/ppsl_div.sv
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module ppsl_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppsl_pkg::div_req_t   req,
	output ppsl_pkg::div_rsp_t   rsp
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, quo_q, rem_q[31:0]};
endmodule

### tb/ppsl_tb_pkg.sv
// Register map shared by the logger testbench files.
`timescale 1ns / 100ps
package ppsl_tb_pkg;
	localparam logic [3:0] REG_PERIOD_LENGTH = 4'd0;
	localparam logic [3:0] REG_HISTORY_DEPTH = 4'd4;
	localparam logic [3:0] REG_INITIAL_START = 4'd8;
	localparam int RING_SLOTS = 64;
endpackage

### tb/ppsl_checker.sv
// Scoreboard for the logger: predicts each result word and compares it.
`timescale 1ns / 100ps
module ppsl_checker
	import ppsl_pkg::*;
	import ppsl_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_word_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          pending,
	output int          errors,
	output int          n_words,
	output int          n_closed,
	output int          n_queries
);
	logic [31:0] cfg_len;
	logic [6:0]  cfg_depth;

	logic [31:0] last_t;
	logic [31:0] per_begin;
	logic [31:0] prev_t;
	logic        have_rd;
	logic [15:0] run_min;
	logic [15:0] run_max;
	logic [63:0] wsum;
	logic [31:0] ring_start [RING_SLOTS];
	logic [15:0] ring_min [RING_SLOTS];
	logic [15:0] ring_max [RING_SLOTS];
	int unsigned ring_head;
	int unsigned ring_count;

	out_word_t expected_q [$];

	assign pending = expected_q.size();

	function automatic int unsigned slot_back(int unsigned back);
		return (ring_head + RING_SLOTS - (back % RING_SLOTS)) % RING_SLOTS;
	endfunction

	function automatic logic [15:0] window_extreme(logic [31:0] ws, logic [31:0] we,
			bit want_max);
		bit          started;
		logic [15:0] lim;
		int unsigned s;
		started = 0;
		lim = want_max ? 16'd0 : VALUE_CEIL;
		if (ring_count == 0)
			return 16'd0;
		if (ring_start[slot_back(ring_count)] > we || ring_start[slot_back(1)] < ws)
			return 16'd0;
		for (int unsigned k = 1; k <= ring_count; k++) begin
			s = slot_back(k);
			if (!started && ring_start[s] < we)
				started = 1;
			if (started) begin
				if (ring_start[s] < ws)
					break;
				if (want_max && ring_max[s] > lim)
					lim = ring_max[s];
				if (!want_max && ring_min[s] < lim)
					lim = ring_min[s];
			end
		end
		return lim;
	endfunction

	function automatic out_word_t predict_word(in_word_t w);
		out_word_t   r;
		logic [31:0] span;
		logic [63:0] avg;
		logic [63:0] prod;
		int unsigned depth;
		r = '0;
		case (w.cmd)
			CMD_READING: begin
				if (w.fetch_time > last_t) begin
					if ({1'b0, w.fetch_time} > {1'b0, per_begin} + {1'b0, cfg_len}) begin
						if (have_rd) begin
							span = prev_t - per_begin;
							avg = (span != 0) ? wsum / {32'd0, span} : 64'd0;
							if (avg > 64'hFFFF)
								avg = 64'hFFFF;
							r.period_closed = 1'b1;
							r.closed_start = per_begin;
							r.closed_min = run_min;
							r.closed_max = run_max;
							r.closed_average = avg[15:0];
							depth = cfg_depth;
							if (depth == 0)
								depth = 1;
							if (depth > RING_SLOTS)
								depth = RING_SLOTS;
							ring_start[ring_head] = per_begin;
							ring_min[ring_head] = run_min;
							ring_max[ring_head] = run_max;
							ring_head = (ring_head + 1) % RING_SLOTS;
							if (ring_count < depth)
								ring_count++;
						end
						have_rd = 0;
						run_min = 0;
						run_max = 0;
						wsum = 0;
						per_begin = (cfg_len != 0) ? w.fetch_time - (w.fetch_time % cfg_len)
							: w.fetch_time;
						prev_t = per_begin;
					end
					prod = {48'd0, w.power_value} * {32'd0, w.fetch_time - prev_t};
					wsum = (wsum > ~prod) ? '1 : wsum + prod;
					if (!have_rd) begin
						run_min = w.power_value;
						run_max = w.power_value;
					end else begin
						if (w.power_value > run_max)
							run_max = w.power_value;
						if (w.power_value < run_min)
							run_min = w.power_value;
					end
					have_rd = 1;
					prev_t = w.fetch_time;
					last_t = w.fetch_time;
					r.accepted = 1'b1;
				end
			end
			CMD_RESTART: begin
				have_rd = 0;
				run_min = 0;
				run_max = 0;
				wsum = 0;
				ring_head = 0;
				ring_count = 0;
				per_begin = w.fetch_time;
				prev_t = w.fetch_time;
			end
			CMD_MAX_WIN, CMD_MIN_WIN:
				r.query_value = window_extreme(w.window_start, w.window_end,
					w.cmd == CMD_MAX_WIN);
			CMD_MAX_LEN, CMD_MIN_LEN:
				r.query_value = window_extreme(per_begin - w.window_length, per_begin,
					w.cmd == CMD_MAX_LEN);
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			cfg_len = PERIOD_LENGTH_RST;
			cfg_depth = 7'd64;
			last_t = 0;
			per_begin = 0;
			prev_t = 0;
			have_rd = 0;
			run_min = 0;
			run_max = 0;
			wsum = 0;
			ring_head = 0;
			ring_count = 0;
			expected_q.delete();
			errors = 0;
			n_words = 0;
			n_closed = 0;
			n_queries = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					REG_PERIOD_LENGTH: cfg_len = pwdata;
					REG_HISTORY_DEPTH: cfg_depth = pwdata[6:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				n_words++;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected result word %p", out_data);
				end else begin
					e = expected_q[0];
					expected_q.delete(0);
					if (out_data.accepted !== e.accepted
							|| out_data.period_closed !== e.period_closed
							|| out_data.closed_start !== e.closed_start
							|| out_data.closed_min !== e.closed_min
							|| out_data.closed_max !== e.closed_max
							|| out_data.closed_average !== e.closed_average
							|| out_data.query_value !== e.query_value) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: word %0d expected %p got %p", n_words, e, out_data);
					end
					if (e.period_closed)
						n_closed++;
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.cmd inside {CMD_MAX_WIN, CMD_MIN_WIN, CMD_MAX_LEN, CMD_MIN_LEN})
					n_queries++;
				expected_q.insert(expected_q.size(), predict_word(in_data));
			end
		end
	end
endmodule

### tb/tb_power_period_stats_logger.sv
// Testbench top for the power period statistics logger: stimulus and verdict.
`timescale 1ns / 100ps
module tb_power_period_stats_logger;
	import ppsl_pkg::*;
	import ppsl_tb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          pending;
	int          errors;
	int          n_words;
	int          n_closed;
	int          n_queries;

	int          send_idle;
	int          recv_stall;
	int          hold_req;
	int          hold_seen;
	int          hold_left;
	logic [31:0] tnow;
	logic [31:0] plen;

	ppsl_if #(.word_t(in_word_t))  in_ch ();
	ppsl_if #(.word_t(out_word_t)) out_ch ();

	power_period_stats_logger dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ppsl_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.pending(pending), .errors(errors), .n_words(n_words),
		.n_closed(n_closed), .n_queries(n_queries)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

	// receiver: random stalls plus long hold-offs counted here
	initial begin
		out_ch.ready = 1'b0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_left = hold_req;
				hold_seen = hold_req;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	task automatic cfg_write(logic [3:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_PERIOD_LENGTH)
			plen = value;
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic send(in_word_t w);
		if ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic stop_sending();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_word_t mk(logic [2:0] cmd, logic [15:0] pv, logic [31:0] ft,
			logic [31:0] ws = 0, logic [31:0] we = 0, logic [31:0] wl = 0);
		in_word_t w;
		w.cmd = cmd;
		w.power_value = pv;
		w.fetch_time = ft;
		w.window_start = ws;
		w.window_end = we;
		w.window_length = wl;
		return w;
	endfunction

	function automatic in_word_t random_word();
		in_word_t    w;
		int unsigned pick;
		int unsigned stepmax;
		logic [31:0] a;
		w = '0;
		w.power_value = $urandom;
		w.window_start = $urandom;
		w.window_end = $urandom;
		w.window_length = $urandom;
		w.fetch_time = $urandom;
		pick = $urandom_range(99);
		stepmax = (plen >= 2 && plen <= 5000) ? plen * 2 : 300;
		if (pick < 58) begin
			w.cmd = CMD_READING;
			if ($urandom_range(99) < 3 && tnow < 32'hF000_0000)
				tnow += $urandom_range(1, 1 << 20);
			else if (tnow < 32'hF000_0000)
				tnow += $urandom_range(1, stepmax);
			w.fetch_time = tnow;
		end else if (pick < 64) begin
			w.cmd = CMD_READING;
			w.fetch_time = $urandom_range(0, tnow);
		end else if (pick < 66) begin
			w.cmd = CMD_RESTART;
			w.fetch_time = $urandom_range(0, tnow);
		end else if (pick < 68) begin
			w.cmd = 3'($urandom_range(6, 7));
		end else begin
			w.cmd = 3'($urandom_range(CMD_MAX_WIN, CMD_MIN_LEN));
			if ($urandom_range(99) >= 20) begin
				a = $urandom_range(0, tnow);
				w.window_start = a;
				w.window_end = a + $urandom_range(0, stepmax * 8);
				w.window_length = $urandom_range(0, stepmax * 10);
			end
		end
		return w;
	endfunction

	initial begin
		logic [31:0] lens [6];
		logic [6:0]  depths [6];
		int          idle_s [4];
		int          idle_r [4];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		send_idle = 0;
		recv_stall = 0;
		hold_req = 0;
		tnow = 0;
		plen = PERIOD_LENGTH_RST;
		lens = '{32'd50, 32'd1, 32'd0, 32'd7, 32'hFFFF_FFFF, 32'd1000};
		depths = '{7'd3, 7'd1, 7'd0, 7'd127, 7'd64, 7'd5};
		idle_s = '{0, 86, 0, 26};
		idle_r = '{0, 0, 86, 26};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stale at zero, extremes, close, all queries, restart, unused
		send(mk(CMD_MIN_WIN, 16'h1234, 0, 0, 32'hFFFF_FFFF));
		send(mk(CMD_READING, 16'hFFFF, 0));
		send(mk(CMD_READING, 16'hFFFF, 10));
		send(mk(CMD_READING, 16'h0000, 500));
		send(mk(CMD_READING, 16'h8000, 500));
		send(mk(CMD_READING, 16'h0001, 1000));
		send(mk(CMD_READING, 16'h0100, 1001));
		send(mk(CMD_READING, 16'h00FF, 2500));
		send(mk(CMD_READING, 16'h7777, 3200));
		send(mk(CMD_MAX_WIN, 0, 0, 0, 32'hFFFF_FFFF));
		send(mk(CMD_MIN_WIN, 0, 0, 0, 32'hFFFF_FFFF));
		send(mk(CMD_MAX_WIN, 0, 0, 5000, 6000));
		send(mk(CMD_MIN_WIN, 0, 0, 0, 0));
		send(mk(CMD_MAX_WIN, 0, 0, 1500, 1800));
		send(mk(CMD_MIN_WIN, 0, 0, 1500, 1800));
		send(mk(CMD_MAX_LEN, 0, 0, 0, 0, 2000));
		send(mk(CMD_MIN_LEN, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send(mk(3'd6, 16'hFFFF, 32'hFFFF_FFFF, '1, '1, '1));
		send(mk(3'd7, 0, 0));
		send(mk(CMD_RESTART, 0, 3000));
		send(mk(CMD_MAX_LEN, 0, 0, 0, 0, 100));
		send(mk(CMD_READING, 16'h4242, 3300));
		tnow = 3300;
		stop_sending();

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			cfg_write(REG_PERIOD_LENGTH, lens[ph]);
			cfg_write(REG_HISTORY_DEPTH, {25'd0, depths[ph]});
			cfg_write(REG_INITIAL_START, $urandom);
			send_idle = idle_s[ph % 4];
			recv_stall = idle_r[ph % 4];
			for (int i = 0; i < 213; i++) begin
				if (ph == 1 && i == 40)
					hold_req = 400;
				if (ph == 2 && i == 100) begin
					stop_sending();
					while (pending != 0)
						@(posedge clk);
				end
				send(random_word());
			end
			stop_sending();
		end

		// timestamps at the top of the range, then everything goes stale
		drain();
		send_idle = 0;
		recv_stall = 0;
		send(mk(CMD_RESTART, 0, 32'hFFFF_FF00));
		send(mk(CMD_READING, 16'hABCD, 32'hFFFF_FFF0));
		send(mk(CMD_READING, 16'h5432, 32'hFFFF_FFFF));
		send(mk(CMD_READING, 16'h1111, 32'hFFFF_FFFF));
		send(mk(CMD_MAX_LEN, 0, 0, 0, 0, 32'hFFFF_FFFF));
		stop_sending();

		drain();
		$display("covered %0d result words, %0d period closes, %0d queries",
			n_words, n_closed, n_queries);
		$display("six register settings, four idle patterns, long output hold-off");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
